// File: rtl/piecewise_linear_table_interp_top_assert.svh
// Assertion macros shared by the lookup table block
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a condition at every clock edge out of reset
`define PLTI_ASSERT_NOW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that a condition holds in the cycle after a trigger
`define PLTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PLTI_ASSERT_NOW(lbl, expr, msg)
`define PLTI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/plin_pkg.sv
// Constants and types shared by the lookup table block
package plin_pkg;
  localparam int TABLE_DEPTH = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_FORWARD = 2'd1;
  localparam logic [1:0] MODE_REVERSE = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_RES  = 5'b10000
  } state_t;
endpackage

// File: rtl/plin_ram.sv
// Generic single-write, single-read RAM with registered read data
module plin_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/piecewise_linear_table_interp_top.sv
// Top level of the piecewise-linear lookup table with interpolation
//
// Input channel (in_*): one word per item. in_tuser carries the mode
// (write entry, forward x to y, reverse y to x). A write stores one point
// pair at entry_index and gives no result. A lookup scans the table one
// entry per cycle, read from the x and y RAMs, then runs a 32x32 multiply
// and a restoring divider that retires one quotient bit per cycle. The
// scan is paced by the single RAM read port and the divider has 32 steps;
// a miss walks all n entries in use but skips the divider. Fewer than two
// entries in use give a miss. in_tready is low while a lookup runs.
// Result channel (out_*): one word per lookup, result in out_tdata and the
// in-range flag in out_tuser; a miss returns zero with the flag clear.
// The result sits in an output register; if the receiver stalls the block
// holds its finished result and waits before taking the next item.
// cfg_we writes the count of entries in use (saturates at the depth).
// Reset clears the count and the control state; RAM contents stay
// undefined until written.
`include "piecewise_linear_table_interp_top_assert.svh"

module piecewise_linear_table_interp_top (
  input  logic         clk,
  input  logic         rst_n,
  // configuration: entries_in_use
  input  logic         cfg_we,
  input  logic [8:0]   cfg_wdata,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // entry_index[7:0], entry_x[39:8], entry_y[71:40],
                                   // query_value[103:72]
  input  logic [1:0]   in_tuser,   // mode[1:0]
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // result_value[31:0]
  output logic         out_tuser   // in_range[0]
);
  localparam int VW = plin_pkg::VALUE_WIDTH;
  localparam int AW = plin_pkg::ADDR_W;
  localparam int CW = plin_pkg::CNT_W;
  localparam int SW = $clog2(VW);

  plin_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]        cfg_count_r;
  logic [CW-1:0]        n_sat;
  logic                 in_acc;
  logic [AW-1:0]        wr_idx;
  logic signed [VW-1:0] wr_x, wr_y, wr_q;

  logic                 fwd_r;
  logic signed [VW-1:0] q_r;
  logic [AW-1:0]        rd_addr_r;
  logic [CW-1:0]        issued_r, recv_r;
  logic                 dv_r;
  logic                 issue;

  logic [VW-1:0]        x_rd, y_rd;
  logic signed [VW-1:0] cur_key, cur_oth;
  logic signed [VW-1:0] prev_key_r, prev_oth_r;
  logic                 bracket;

  logic [VW:0]          span_s;
  logic [VW:0]          den_s;
  logic [VW:0]          num_s;
  logic [VW-1:0]        den_r, num_r, mag_r;
  logic                 neg_r, den_zero_r;
  logic signed [VW-1:0] base_r;
  logic                 hit_r;

  logic [2*VW-1:0]      prod;
  logic [VW-1:0]        rem_r, quo_r;
  logic [VW:0]          trial, trial_sub;
  logic                 ge;
  logic [SW-1:0]        step_r;

  logic [VW-1:0]        res_val;
  logic                 out_free;
  logic                 out_tvalid_r;
  logic [VW-1:0]        out_data_r;
  logic                 out_hit_r;

  // unpack the input word
  assign in_acc = in_tvalid && in_tready;
  assign wr_idx = in_tdata[7:0];
  assign wr_x   = $signed(in_tdata[39:8]);
  assign wr_y   = $signed(in_tdata[71:40]);
  assign wr_q   = $signed(in_tdata[103:72]);

  assign in_tready = (state_r == plin_pkg::ST_IDLE);

  // saturate the count of entries in use to the table depth
  assign n_sat = (cfg_count_r > CW'(plin_pkg::TABLE_DEPTH)) ?
                 CW'(plin_pkg::TABLE_DEPTH) : cfg_count_r;

  // point storage
  plin_ram #(.WIDTH(VW), .DEPTH(plin_pkg::TABLE_DEPTH)) u_ram_x (
    .clk   (clk),
    .we    (in_acc && (in_tuser == plin_pkg::MODE_WRITE)),
    .waddr (wr_idx),
    .wdata (wr_x),
    .raddr (rd_addr_r),
    .rdata (x_rd)
  );

  plin_ram #(.WIDTH(VW), .DEPTH(plin_pkg::TABLE_DEPTH)) u_ram_y (
    .clk   (clk),
    .we    (in_acc && (in_tuser == plin_pkg::MODE_WRITE)),
    .waddr (wr_idx),
    .wdata (wr_y),
    .raddr (rd_addr_r),
    .rdata (y_rd)
  );

  // pick search key and interpolated coordinate by direction
  assign cur_key = fwd_r ? $signed(x_rd) : $signed(y_rd);
  assign cur_oth = fwd_r ? $signed(y_rd) : $signed(x_rd);
  assign issue   = (issued_r < n_sat);
  assign bracket = (recv_r != '0) && (prev_key_r <= q_r) && (cur_key >= q_r);

  // segment operands, from the previous and current entries
  assign span_s = {cur_oth[VW-1], cur_oth} - {prev_oth_r[VW-1], prev_oth_r};
  assign den_s  = {cur_key[VW-1], cur_key} - {prev_key_r[VW-1], prev_key_r};
  assign num_s  = {q_r[VW-1], q_r} - {prev_key_r[VW-1], prev_key_r};

  // shared arithmetic: multiply, then one restoring divide step per cycle
  assign prod      = mag_r * num_r;
  assign trial     = {rem_r, quo_r[VW-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign ge        = (trial >= {1'b0, den_r});

  assign res_val  = neg_r ? (base_r - quo_r) : (base_r + quo_r);
  assign out_free = !out_tvalid_r || out_tready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plin_pkg::ST_IDLE: begin
        if (in_acc && ((in_tuser == plin_pkg::MODE_FORWARD) ||
                       (in_tuser == plin_pkg::MODE_REVERSE))) begin
          state_nxt = (n_sat >= CW'(2)) ? plin_pkg::ST_SCAN : plin_pkg::ST_RES;
        end
      end
      plin_pkg::ST_SCAN: begin
        if (dv_r) begin
          if (bracket) begin
            state_nxt = plin_pkg::ST_MUL;
          end else if (recv_r == n_sat - CW'(1)) begin
            state_nxt = plin_pkg::ST_RES;
          end
        end
      end
      plin_pkg::ST_MUL: begin
        state_nxt = den_zero_r ? plin_pkg::ST_RES : plin_pkg::ST_DIV;
      end
      plin_pkg::ST_DIV: begin
        if (step_r == '1) begin
          state_nxt = plin_pkg::ST_RES;
        end
      end
      plin_pkg::ST_RES: begin
        if (out_free) begin
          state_nxt = plin_pkg::ST_IDLE;
        end
      end
      default: state_nxt = plin_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= plin_pkg::ST_IDLE;
      cfg_count_r  <= '0;
      out_tvalid_r <= 1'b0;
      dv_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_count_r <= cfg_wdata;
      end
      dv_r <= (state_r == plin_pkg::ST_SCAN) && issue && !(dv_r && bracket);
      if ((state_r == plin_pkg::ST_RES) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      plin_pkg::ST_IDLE: begin
        // start a lookup
        if (in_acc) begin
          fwd_r     <= (in_tuser == plin_pkg::MODE_FORWARD);
          q_r       <= wr_q;
          rd_addr_r <= (in_tuser == plin_pkg::MODE_FORWARD) ? '0 : AW'(n_sat - CW'(1));
          issued_r  <= '0;
          recv_r    <= '0;
          hit_r     <= 1'b0;
        end
      end
      plin_pkg::ST_SCAN: begin
        // advance the read address while entries remain
        if (issue) begin
          rd_addr_r <= fwd_r ? (rd_addr_r + AW'(1)) : (rd_addr_r - AW'(1));
          issued_r  <= issued_r + CW'(1);
        end
        // capture the bracketing segment or shift the current entry back
        if (dv_r) begin
          if (bracket) begin
            hit_r      <= 1'b1;
            den_r      <= den_s[VW-1:0];
            num_r      <= num_s[VW-1:0];
            neg_r      <= span_s[VW];
            mag_r      <= span_s[VW] ? VW'(-span_s) : span_s[VW-1:0];
            base_r     <= prev_oth_r;
            den_zero_r <= (cur_key == prev_key_r);
          end else begin
            prev_key_r <= cur_key;
            prev_oth_r <= cur_oth;
            recv_r     <= recv_r + CW'(1);
          end
        end
      end
      plin_pkg::ST_MUL: begin
        // load the product into the divider; a zero-width segment keeps its base
        rem_r  <= den_zero_r ? '0 : prod[2*VW-1:VW];
        quo_r  <= den_zero_r ? '0 : prod[VW-1:0];
        step_r <= '0;
      end
      plin_pkg::ST_DIV: begin
        rem_r  <= ge ? trial_sub[VW-1:0] : trial[VW-1:0];
        quo_r  <= {quo_r[VW-2:0], ge};
        step_r <= step_r + SW'(1);
      end
      plin_pkg::ST_RES: begin
        // hand the result to the output register
        if (out_free) begin
          out_data_r <= hit_r ? res_val : '0;
          out_hit_r  <= hit_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

  // checks
  `PLTI_ASSERT_NOW(a_miss_is_zero, !out_tvalid || out_tuser || (out_tdata == '0), "miss word not zero")
  `PLTI_ASSERT_NOW(a_quo_bounded, !((state_r == plin_pkg::ST_RES) && hit_r) || (quo_r <= mag_r), "quotient exceeds span")
  `PLTI_ASSERT_NOW(a_scan_count, !(state_r == plin_pkg::ST_SCAN) || ((recv_r < n_sat) && (issued_r <= n_sat)), "scan ran past entries in use")
  `PLTI_ASSERT_NEXT(a_busy_after_lookup, in_acc && ((in_tuser == plin_pkg::MODE_FORWARD) || (in_tuser == plin_pkg::MODE_REVERSE)), !in_tready, "ready during lookup")
endmodule
